>>> rtl/jsu_pkg.sv
// JSON string unescape package: result kinds, error codes and the job record
// passed from the front end to the UTF-8 back end. No dependencies.
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam logic [1:0] ERR_NO_OPEN  = 2'd0;
  localparam logic [1:0] ERR_BAD_ESC  = 2'd1;
  localparam logic [1:0] ERR_BAD_HEX  = 2'd2;
  localparam logic [1:0] ERR_NUL      = 2'd3;

  localparam int unsigned CpW = 16;

  // One job per input byte that yields results.
  typedef struct packed {
    kind_e            kind;
    logic [CpW-1:0]   cp;
    logic [1:0]       err;
  } job_t;

endpackage

>>> rtl/jsu_in_if.sv
// Input byte channel: valid/ready handshake carrying one raw JSON byte.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/jsu_out_if.sv
// Result channel: valid/ready handshake carrying one decoded result.
// Depends on nothing.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

>>> rtl/jsu_front.sv
// Front end: accepts input bytes, tracks string/escape/hex phase and emits
// one job per byte that produces results. Uses jsu_pkg.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  output logic          job_valid_o,
  output jsu_pkg::job_t job_o,
  input  logic          job_ready_i
);

  localparam logic [1:0] PhWait = 2'd0;
  localparam logic [1:0] PhStr  = 2'd1;
  localparam logic [1:0] PhEsc  = 2'd2;
  localparam logic [1:0] PhHex  = 2'd3;

  logic [1:0]              phase_q, phase_d;
  logic [1:0]              hex_cnt_q, hex_cnt_d;
  logic [jsu_pkg::CpW-1:0] cp_q, cp_d;
  logic                    accept;
  logic                    push;
  logic                    hex_ok;
  logic [3:0]              hex_val;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && job_ready_i;
  assign job_valid_o = accept && push;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= "0" && in_byte_i <= "9") begin
      hex_val = 4'(in_byte_i - "0");
    end else if (in_byte_i >= "a" && in_byte_i <= "f") begin
      hex_val = 4'(in_byte_i - "a" + 8'd10);
    end else if (in_byte_i >= "A" && in_byte_i <= "F") begin
      hex_val = 4'(in_byte_i - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    push      = 1'b0;
    job_o     = '{kind: jsu_pkg::KIND_BYTE, cp: {8'd0, in_byte_i}, err: '0};
    unique case (phase_q)
      PhWait: begin
        if (in_byte_i == "\"") begin
          phase_d = PhStr;
        end else begin
          push       = 1'b1;
          job_o.kind = jsu_pkg::KIND_ERROR;
          job_o.err  = jsu_pkg::ERR_NO_OPEN;
        end
      end
      PhStr: begin
        unique if (in_byte_i == "\"") begin
          phase_d    = PhWait;
          push       = 1'b1;
          job_o.kind = jsu_pkg::KIND_CLOSE;
        end else if (in_byte_i == "\\") begin
          phase_d = PhEsc;
        end else if (in_byte_i == 8'd0) begin
          phase_d    = PhWait;
          push       = 1'b1;
          job_o.kind = jsu_pkg::KIND_ERROR;
          job_o.err  = jsu_pkg::ERR_NUL;
        end else begin
          push = 1'b1;
        end
      end
      PhEsc: begin
        phase_d = PhStr;
        push    = 1'b1;
        unique case (in_byte_i)
          "\"", "\\", "/": job_o.cp = {8'd0, in_byte_i};
          "b":             job_o.cp = 16'h0008;
          "f":             job_o.cp = 16'h000C;
          "n":             job_o.cp = 16'h000A;
          "r":             job_o.cp = 16'h000D;
          "t":             job_o.cp = 16'h0009;
          "u": begin
            push      = 1'b0;
            phase_d   = PhHex;
            hex_cnt_d = 2'd0;
            cp_d      = '0;
          end
          default: begin
            phase_d    = PhWait;
            job_o.kind = jsu_pkg::KIND_ERROR;
            job_o.err  = jsu_pkg::ERR_BAD_ESC;
          end
        endcase
      end
      default: begin
        if (!hex_ok) begin
          phase_d    = PhWait;
          hex_cnt_d  = 2'd0;
          cp_d       = '0;
          push       = 1'b1;
          job_o.kind = jsu_pkg::KIND_ERROR;
          job_o.err  = jsu_pkg::ERR_BAD_HEX;
        end else if (hex_cnt_q == 2'd3) begin
          phase_d   = PhStr;
          hex_cnt_d = 2'd0;
          cp_d      = '0;
          push      = 1'b1;
          job_o.cp  = {cp_q[11:0], hex_val};
        end else begin
          hex_cnt_d = hex_cnt_q + 2'd1;
          cp_d      = {cp_q[11:0], hex_val};
        end
      end
    endcase
    if (job_o.kind != jsu_pkg::KIND_BYTE) job_o.cp = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhWait;
      hex_cnt_q <= 2'd0;
      cp_q      <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

>>> rtl/jsu_queue.sv
// Small register FIFO of jobs between front and back end.
// Uses jsu_pkg.
module jsu_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  jsu_pkg::job_t push_job_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output jsu_pkg::job_t pop_job_o,
  input  logic          pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  jsu_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/jsu_back.sv
// Back end: expands each job into one to three UTF-8 result bytes through
// a registered output stage. Uses jsu_pkg.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  jsu_pkg::job_t job_i,
  output logic          job_ready_o,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    kind_o,
  output logic [1:0]    error_code_o,
  output logic          last_o,
  input  logic          out_ready_i
);

  logic [1:0] idx_q;
  logic [1:0] nbytes;
  logic [7:0] byte_sel;
  logic       load;
  logic       fin;
  logic       ov_q;
  logic [7:0] byte_q;
  logic [1:0] kind_q, err_q;
  logic       last_q;

  always_comb begin
    if (job_i.kind != jsu_pkg::KIND_BYTE) begin
      nbytes = 2'd1;
    end else if (job_i.cp >= 16'h0001 && job_i.cp <= 16'h007F) begin
      nbytes = 2'd1;
    end else if (job_i.cp <= 16'h07FF) begin
      nbytes = 2'd2;
    end else begin
      nbytes = 2'd3;
    end
  end

  always_comb begin
    byte_sel = 8'h80 | {2'b00, job_i.cp[5:0]};
    unique case (nbytes)
      2'd1: byte_sel = job_i.cp[7:0];
      2'd2: if (idx_q == 2'd0) byte_sel = 8'hC0 | {3'b000, job_i.cp[10:6]};
      default: begin
        if (idx_q == 2'd0)      byte_sel = 8'hE0 | {4'b0000, job_i.cp[15:12]};
        else if (idx_q == 2'd1) byte_sel = 8'h80 | {2'b00, job_i.cp[11:6]};
      end
    endcase
  end

  assign load        = job_valid_i && (!ov_q || out_ready_i);
  assign fin         = (idx_q == nbytes - 2'd1);
  assign job_ready_o = load && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= fin ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_sel;
      kind_q <= job_i.kind;
      err_q  <= job_i.err;
      last_q <= fin;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = byte_q;
  assign kind_o       = kind_q;
  assign error_code_o = err_q;
  assign last_o       = last_q;

endmodule

>>> rtl/json_string_unescape_utf8_core.sv
// JSON string unescaper with UTF-8 output, top level.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
//
// in_i carries raw JSON bytes, one per request; out_o carries results.
// Each result has out_byte, kind (byte, closing quote, error), error_code
// and last, which marks the final result caused by one input byte.
// A byte yields zero to three results: an opening quote, an escape's
// backslash and u, and hex digits before the fourth only change state.
// An accepted byte's job is written into the job queue; the back end
// takes it from there and loads each of its results into the output
// register that drives out_o.
// Throughput: one input byte per cycle while each byte maps to one result
// and out_o stays ready; the back end emits one result per cycle while
// out_o is ready, so a two- or three-byte UTF-8 sequence holds the input
// for its extra bytes once the job queue (QUEUE_DEPTH entries) fills.
// Reset clears the phase to awaiting an opening quote, empties the queue
// and drops any pending result. When the receiver stalls, the output
// register holds its result, the queue fills and then in_i.ready falls.
module json_string_unescape_utf8_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic          job_valid, job_ready;
  jsu_pkg::job_t job;
  logic          q_valid, q_ready;
  jsu_pkg::job_t q_job;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.in_byte),
    .in_ready_o  (in_i.ready),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  jsu_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_job_i   (job),
    .push_ready_o (job_ready),
    .pop_valid_o  (q_valid),
    .pop_job_o    (q_job),
    .pop_ready_i  (q_ready)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (q_job),
    .job_ready_o  (q_ready),
    .out_valid_o  (out_o.valid),
    .out_byte_o   (out_o.out_byte),
    .kind_o       (out_o.kind),
    .error_code_o (out_o.error_code),
    .last_o       (out_o.last),
    .out_ready_i  (out_o.ready)
  );

endmodule

>>> rtl/jsu_checker.sv
// Port-level checks on the result channel of the unescaper, bound to the
// top level. Uses jsu_pkg.
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] kind_i,
  input logic [1:0] error_code_i,
  input logic       last_i
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(kind_i) && $stable(error_code_i) && $stable(last_i))
    else $error("stalled result changed");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != jsu_pkg::KIND_BYTE |-> last_i && out_byte_i == 8'd0)
    else $error("close or error result not single");

  a_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == jsu_pkg::KIND_BYTE && out_byte_i[7:6] == 2'b11
    |-> !last_i)
    else $error("UTF-8 lead byte marked last");

  a_errcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != jsu_pkg::KIND_ERROR |-> error_code_i == 2'd0)
    else $error("error code on non-error result");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .kind_i       (out_o.kind),
  .error_code_i (out_o.error_code),
  .last_i       (out_o.last)
);

>>> tb/json_string_unescape_utf8_core_checker.sv
// Checker for json_string_unescape_utf8_core: watches both channels, predicts the
// decoded results of every accepted byte and compares them in order.
// Depends on jsu_pkg, jsu_in_if and jsu_out_if.
module json_string_unescape_utf8_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsu_in_if           in_mon,
  jsu_out_if          out_mon,
  input  logic        done_i,
  output int unsigned pending_o,
  output int unsigned fail_cnt_o
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = "b";
  localparam logic [7:0] CH_F      = "f";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_U      = "u";

  typedef enum logic [1:0] {ST_OUTSIDE, ST_STRING, ST_ESCAPE, ST_HEX} scan_state_e;

  typedef struct packed {
    logic [7:0]     out_byte;
    jsu_pkg::kind_e kind;
    logic [1:0]     err;
    logic           last;
  } decoded_t;

  decoded_t    decoded_q[$];
  scan_state_e scan_state;
  logic [1:0]  nibbles;
  logic [15:0] cp_acc;
  int unsigned fails;
  bit          leftover_checked;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fails++;
  endtask

  task automatic add_result(input logic [7:0] b, input jsu_pkg::kind_e k,
                            input logic [1:0] e);
    decoded_t r;
    r.out_byte = b;
    r.kind     = k;
    r.err      = e;
    r.last     = 1'b0;
    decoded_q.push_back(r);
  endtask

  task automatic raise_error(input logic [1:0] e);
    scan_state = ST_OUTSIDE;
    nibbles    = 2'd0;
    cp_acc     = 16'h0000;
    add_result(8'h00, jsu_pkg::KIND_ERROR, e);
  endtask

  // Code point 0 falls into the two-byte form on purpose (C0 80).
  task automatic add_utf8(input logic [15:0] cp);
    if (cp != 16'h0000 && cp <= 16'h007F) begin
      add_result(cp[7:0], jsu_pkg::KIND_BYTE, 2'b00);
    end else if (cp <= 16'h07FF) begin
      add_result(8'hC0 | {3'b000, cp[10:6]}, jsu_pkg::KIND_BYTE, 2'b00);
      add_result(8'h80 | {2'b00, cp[5:0]}, jsu_pkg::KIND_BYTE, 2'b00);
    end else begin
      add_result(8'hE0 | {4'h0, cp[15:12]}, jsu_pkg::KIND_BYTE, 2'b00);
      add_result(8'h80 | {2'b00, cp[11:6]}, jsu_pkg::KIND_BYTE, 2'b00);
      add_result(8'h80 | {2'b00, cp[5:0]}, jsu_pkg::KIND_BYTE, 2'b00);
    end
  endtask

  function automatic int hex_digit_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - 8'h30);
    if (b >= "a" && b <= "f") return int'(b - 8'h61) + 10;
    if (b >= "A" && b <= "F") return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  task automatic unescape_byte(input logic [7:0] b);
    int          d;
    int unsigned base;
    logic [15:0] cp_done;
    base = decoded_q.size();
    d    = hex_digit_value(b);
    case (scan_state)
      ST_OUTSIDE: begin
        if (b == CH_QUOTE) scan_state = ST_STRING;
        else raise_error(jsu_pkg::ERR_NO_OPEN);
      end
      ST_STRING: begin
        if (b == CH_QUOTE) begin
          scan_state = ST_OUTSIDE;
          add_result(8'h00, jsu_pkg::KIND_CLOSE, 2'b00);
        end else if (b == CH_BSLASH) begin
          scan_state = ST_ESCAPE;
        end else if (b == 8'h00) begin
          raise_error(jsu_pkg::ERR_NUL);
        end else begin
          add_utf8({8'h00, b});
        end
      end
      ST_ESCAPE: begin
        scan_state = ST_STRING;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: add_utf8({8'h00, b});
          CH_B: add_utf8(16'h0008);
          CH_F: add_utf8(16'h000C);
          CH_N: add_utf8(16'h000A);
          CH_R: add_utf8(16'h000D);
          CH_T: add_utf8(16'h0009);
          CH_U: begin
            scan_state = ST_HEX;
            nibbles    = 2'd0;
            cp_acc     = 16'h0000;
          end
          default: raise_error(jsu_pkg::ERR_BAD_ESC);
        endcase
      end
      default: begin
        if (d < 0) begin
          raise_error(jsu_pkg::ERR_BAD_HEX);
        end else begin
          cp_acc = {cp_acc[11:0], d[3:0]};
          if (nibbles == 2'd3) begin
            scan_state = ST_STRING;
            nibbles    = 2'd0;
            cp_done    = cp_acc;
            cp_acc     = 16'h0000;
            add_utf8(cp_done);
          end else begin
            nibbles = nibbles + 2'd1;
          end
        end
      end
    endcase
    if (decoded_q.size() > base) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t w;
    if (!rst_ni) begin
      decoded_q.delete();
      scan_state       = ST_OUTSIDE;
      nibbles          = 2'd0;
      cp_acc           = 16'h0000;
      fails            = 0;
      leftover_checked = 1'b0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected result byte %02h kind %0d err %0d last %0b",
                           out_mon.out_byte, out_mon.kind, out_mon.error_code,
                           out_mon.last));
        end else begin
          w = decoded_q.pop_front();
          if (out_mon.out_byte !== w.out_byte)
            report($sformatf("out_byte %02h, want %02h", out_mon.out_byte, w.out_byte));
          if (out_mon.kind !== w.kind)
            report($sformatf("kind %0d, want %0d", out_mon.kind, w.kind));
          if (out_mon.error_code !== w.err)
            report($sformatf("error_code %0d, want %0d", out_mon.error_code, w.err));
          if (out_mon.last !== w.last)
            report($sformatf("last %0b, want %0b", out_mon.last, w.last));
        end
      end
      if (in_mon.valid && in_mon.ready) unescape_byte(in_mon.in_byte);
      if (done_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (decoded_q.size() != 0)
          report($sformatf("%0d results never arrived", decoded_q.size()));
      end
      pending_o  <= decoded_q.size();
      fail_cnt_o <= fails;
    end
  end

endmodule

>>> tb/json_string_unescape_utf8_core_tb.sv
// Testbench top for json_string_unescape_utf8_core: drives JSON text bytes with
// random gaps and back-pressure, and gives the verdict from the checker.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, the core and the checker module.
module json_string_unescape_utf8_core_tb;

  localparam int unsigned RANDOM_BYTES = 420;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned HOLD_CYCLES  = 80;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = "b";
  localparam logic [7:0] CH_F      = "f";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_U      = "u";

  logic        clk_i;
  logic        rst_ni;
  logic        done;
  int unsigned pending;
  int unsigned fail_cnt;
  bit          hold_req;
  bit          hold_done;
  bit          tx_calm;
  bit          rx_calm;
  logic [7:0]  json_text[$];

  jsu_in_if  in_if();
  jsu_out_if out_if();

  json_string_unescape_utf8_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  json_string_unescape_utf8_core_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .done_i    (done),
    .pending_o (pending),
    .fail_cnt_o(fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_cycles(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] b);
    return b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U};
  endfunction

  function automatic bit is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = 8'h30 + v;
    else c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    return c;
  endfunction

  function automatic logic [7:0] escape_letter(input int unsigned idx);
    case (idx)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [15:0] random_cp();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(1, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      3: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic push_text(input logic [7:0] b);
    json_text.push_back(b);
  endtask

  task automatic push_unicode(input logic [15:0] cp);
    push_text(CH_BSLASH);
    push_text(CH_U);
    for (int i = 3; i >= 0; i--) push_text(hex_char(cp[i*4 +: 4]));
  endtask

  // Mostly well-formed strings; the tail sometimes breaks the string instead.
  task automatic push_random_string();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  b;
    push_text(CH_QUOTE);
    n = $urandom_range(0, 10);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CH_QUOTE || b == CH_BSLASH);
        push_text(b);
      end else if (pick < 60) begin
        push_text(8'($urandom_range(8'h80, 8'hFF)));
      end else if (pick < 65) begin
        push_text(8'($urandom_range(8'h01, 8'h1F)));
      end else if (pick < 80) begin
        push_text(CH_BSLASH);
        push_text(escape_letter($urandom_range(0, 7)));
      end else begin
        push_unicode(random_cp());
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      push_text(CH_QUOTE);
    end else if (pick < 90) begin
      push_text(CH_BSLASH);
      do b = 8'($urandom); while (is_escape_letter(b));
      push_text(b);
    end else if (pick < 95) begin
      push_text(CH_BSLASH);
      push_text(CH_U);
      repeat ($urandom_range(0, 3)) push_text(hex_char(4'($urandom)));
      do b = 8'($urandom); while (is_hex(b));
      push_text(b);
    end else begin
      push_text(8'h00);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned g;
    if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
    g = idle_cycles(tx_calm);
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  initial begin
    int unsigned directed_len;
    rst_ni        = 1'b0;
    done          = 1'b0;
    hold_req      = 1'b0;
    tx_calm       = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;

    // Bytes before any opening quote, raw range ends, \u0000, a surrogate,
    // a close, a bad escape, a bad hex digit and a raw NUL.
    json_text = '{8'h00, 8'hFF, CH_QUOTE, 8'h01, 8'h7F, 8'h80, 8'hFF,
                  CH_BSLASH, CH_U, "0", "0", "0", "0",
                  CH_BSLASH, CH_U, "D", "8", "f", "F", CH_QUOTE,
                  CH_QUOTE, CH_BSLASH, "q",
                  CH_QUOTE, CH_BSLASH, CH_U, "g",
                  CH_QUOTE, 8'h00};
    directed_len = json_text.size();
    while (json_text.size() < directed_len + RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) push_text(8'($urandom));
      end else begin
        push_random_string();
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (json_text[i]) begin
      if (i == directed_len) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        hold_req = 1'b1;
      end
      send_byte(json_text[i]);
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned g;
    hold_done    = 1'b0;
    rx_calm      = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
      g = idle_cycles(rx_calm);
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> json_string_unescape_utf8_core.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_core.sv
rtl/jsu_checker.sv
tb/json_string_unescape_utf8_core_checker.sv
tb/json_string_unescape_utf8_core_tb.sv
